@@ src/mbe_pkg.sv @@
package mbe_pkg;

	// Fixed-point format of z and c
	localparam int FRAC_BITS = 28;
	localparam int C_W       = 32;
	localparam int CNT_W     = 16;

	// z parts stay below 2^(FRAC_BITS+2) + 2^(C_W-1) in magnitude after any update
	localparam int Z_W    = ((FRAC_BITS + 2 > C_W - 1) ? FRAC_BITS + 2 : C_W - 1) + 2;
	// multiplier operand: a part below 2 in magnitude, signed
	localparam int OP_W   = FRAC_BITS + 2;
	localparam int PROD_W = 2 * OP_W;

	localparam logic signed [Z_W-1:0] TWO_Z =
		{{(Z_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
	localparam logic signed [Z_W-1:0] NEG_TWO_Z = -TWO_Z;
	localparam logic signed [PROD_W-1:0] FOUR_P =
		{{(PROD_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

	// register port
	localparam int APB_DW    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = '0;
	localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd256;

	typedef struct packed {
		logic load;  // take a new point, clear z and the count
		logic mul;   // form the squares and the cross product
		logic upd;   // write back the new z, advance the count
		logic done;  // hand the count to the output word
	} mbe_cmd_t;

	typedef struct packed {
		logic at_limit;
		logic escape;
	} mbe_sts_t;

endpackage

@@ src/mandelbrot_escape_time_top.sv @@
// Channel   | Handshake          | Words carried
// ----------+--------------------+-------------------------------------------
// input     | in_valid/in_ready  | c_real, c_imag (signed Q4.28), frame_end
// output    | out_valid/out_ready| escape_count (16 bits), frame_end_out
// register  | APB psel/penable   | max_iterations at byte address 0
//
// Each iteration of z <- z*z + c passes S_MUL, through the three 30x30
// multipliers, then S_UPD, through the escape compare and the z write-back. A word
// leaves the loop by the escape compare in S_UPD or by the limit test in S_MUL,
// and then waits in S_FIN until the output word is free.
// A new input word is taken while the previous result still waits at the output.
// Reset (arst_n low) empties the output and sets max_iterations to 256.
module mandelbrot_escape_time_top import mbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	// input words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [C_W-1:0] c_real,
	input  logic signed [C_W-1:0] c_imag,
	input  logic                  frame_end,
	// output words
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_W-1:0]      escape_count,
	output logic                  frame_end_out
);

	logic [CNT_W-1:0] max_iterations_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] escape_count_q;
	logic             frame_end_out_q;

	mbe_cmd_t         cmd;
	mbe_sts_t         sts;
	logic             out_free;
	logic [CNT_W-1:0] count;
	logic             fe_held;
	logic             reg_hit;

	// register port: single register, no wait states
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_MAX_ITER);
	assign prdata  = reg_hit ? {{(APB_DW-CNT_W){1'b0}}, max_iterations_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iterations_q <= MAX_ITER_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			// only the low half of the write data is kept
			max_iterations_q <= pwdata[CNT_W-1:0];
		end
	end

	// output word may load in the cycle it is drained
	assign out_free = !out_valid_q || out_ready;

	mbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbe_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.c_real         (c_real),
		.c_imag         (c_imag),
		.frame_end      (frame_end),
		.limit          (max_iterations_q),
		.sts            (sts),
		.count          (count),
		.frame_end_held (fe_held)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			escape_count_q  <= count;
			frame_end_out_q <= fe_held;
		end
	end

	assign out_valid     = out_valid_q;
	assign escape_count  = escape_count_q;
	assign frame_end_out = frame_end_out_q;

	// checks that the count does not pass the limit while a point is in flight
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> count <= max_iterations_q)
		else $error("iteration count passed the limit");

	// a finished count is only loaded into a free output word
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending output word");

	// an accepted word keeps the engine busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("engine took a second word while busy");

	// a result is handed over only while a point is held
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> !in_ready)
		else $error("result produced with no point in flight");

endmodule

@@ src/mbe_dp.sv @@
module mbe_dp import mbe_pkg::*; (
	input  logic                    clk,
	input  mbe_cmd_t                cmd,
	input  logic signed [C_W-1:0]   c_real,
	input  logic signed [C_W-1:0]   c_imag,
	input  logic                    frame_end,
	input  logic [CNT_W-1:0]        limit,
	output mbe_sts_t                sts,
	output logic [CNT_W-1:0]        count,
	output logic                    frame_end_held
);

	logic signed [C_W-1:0]    cr_q, ci_q;
	logic                     fe_q;
	logic signed [Z_W-1:0]    re_q, im_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [PROD_W-1:0] rr_q, ii_q, ri_q;
	logic                     big_q;

	logic signed [OP_W-1:0]   op_re, op_im;
	logic                     big;
	logic signed [PROD_W-1:0] sum, diff, diff_sh, ri_sh;
	logic signed [Z_W-1:0]    cr_ext, ci_ext, re_next, im_next;

	// operands are exact whenever the part is below 2; otherwise big overrides
	assign op_re = re_q[OP_W-1:0];
	assign op_im = im_q[OP_W-1:0];
	assign big   = (re_q >= TWO_Z) || (re_q <= NEG_TWO_Z) ||
	               (im_q >= TWO_Z) || (im_q <= NEG_TWO_Z);

	assign sum     = rr_q + ii_q;
	assign diff    = rr_q - ii_q;
	assign diff_sh = diff >>> FRAC_BITS;
	assign ri_sh   = ri_q >>> (FRAC_BITS - 1);
	assign cr_ext  = {{(Z_W-C_W){cr_q[C_W-1]}}, cr_q};
	assign ci_ext  = {{(Z_W-C_W){ci_q[C_W-1]}}, ci_q};
	assign re_next = diff_sh[Z_W-1:0] + cr_ext;
	assign im_next = ri_sh[Z_W-1:0] + ci_ext;

	assign sts.at_limit  = (count_q == limit);
	assign sts.escape    = big_q || (sum >= FOUR_P);
	assign count         = count_q;
	assign frame_end_held = fe_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q    <= c_real;
			ci_q    <= c_imag;
			fe_q    <= frame_end;
			re_q    <= '0;
			im_q    <= '0;
			count_q <= '0;
		end else if (cmd.upd) begin
			re_q    <= re_next;
			im_q    <= im_next;
			count_q <= count_q + 1'b1;
		end
		if (cmd.mul) begin
			rr_q  <= op_re * op_re;
			ii_q  <= op_im * op_im;
			ri_q  <= op_re * op_im;
			big_q <= big;
		end
	end

endmodule

@@ src/mbe_ctrl.sv @@
module mbe_ctrl import mbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_free,
	input  mbe_sts_t sts,
	output mbe_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				// limit test comes before every step
				if (sts.at_limit) begin
					state_d = S_FIN;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				if (sts.escape) begin
					state_d = S_FIN;
				end else begin
					cmd.upd = 1'b1;
					state_d = S_MUL;
				end
			end
			S_FIN: begin
				// hold until the output word is free
				if (out_free) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
